// ----- rtl/core/voct_pkg.sv -----
// Shared constants, types and address formation for the voxel occupancy store.
package voct_pkg;

    localparam int TREE_LEVELS = 5;
    localparam int COORD_W     = 6;
    localparam int STORE_BYTES = 1 << (3 * TREE_LEVELS);
    localparam int ADDR_W      = (TREE_LEVELS == 0) ? 1 : 3 * TREE_LEVELS;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_FILL  = 1'b1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [7:0]         byte_t;
    typedef logic [COORD_W-1:0] coord_t;

    typedef enum logic
    {
        CLR_SWEEP,
        CLR_DONE
    } clr_state_t;

    typedef struct packed
    {
        logic  re;
        addr_t raddr;
        logic  we;
        addr_t waddr;
        byte_t wdata;
    } store_req_t;

    // Coordinate bit b supplies the octant digit at address bits 3(b-1)..3(b-1)+2.
    // Levels beyond the coordinate width take their bits as zero.
    function automatic addr_t voxel_addr(coord_t x, coord_t y, coord_t z);
        addr_t a;
        a = '0;
        for (int b = 1; b <= TREE_LEVELS; b++)
        begin
            if (b < COORD_W)
            begin
                a[3*(b-1)]     = x[b];
                a[3*(b-1) + 1] = y[b];
                a[3*(b-1) + 2] = z[b];
            end
        end
        return a;
    endfunction

endpackage

// ----- rtl/core/voct_store.sv -----
// Occupancy byte memory with its clearing sweep after reset.
module voct_store
    import voct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output byte_t      rd_data,
    output logic       clearing
);

    byte_t      mem [STORE_BYTES];
    byte_t      rd_data_reg;
    clr_state_t state_reg;
    clr_state_t state_next;
    addr_t      clr_addr_reg;
    addr_t      clr_addr_next;
    logic       we;
    addr_t      waddr;
    byte_t      wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CLR_SWEEP;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clearing      = 1'b0;
        unique case (state_reg)
            CLR_SWEEP:
            begin
                clearing      = 1'b1;
                clr_addr_next = clr_addr_reg + addr_t'(1);
                if (clr_addr_reg == addr_t'(STORE_BYTES - 1))
                begin
                    state_next = CLR_DONE;
                end
            end
            CLR_DONE:
            begin
                clearing = 1'b0;
            end
            default:
            begin
                state_next = CLR_SWEEP;
            end
        endcase
    end

    // The sweep owns the write port until every byte has been zeroed.
    assign we    = clearing | req.we;
    assign waddr = clearing ? clr_addr_reg : req.waddr;
    assign wdata = clearing ? '0 : req.wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/voxel_octree_occupancy_test_and_set.sv -----
// Top level of the voxel occupancy test-and-set block.
// After reset the block zeroes its occupancy memory, one byte per cycle, over all
// STORE_BYTES bytes (32768 with five tree levels); busy stays high throughout and no item
// is taken. Then busy stays low and an item may be started in every cycle. Each item's
// result appears on done and was_filled in the cycle after it is accepted, for that one
// cycle only, and must be captured then. The result comes from the registered memory read;
// a fill followed at once by an item on the same byte is served from a forwarding register.
module voxel_octree_occupancy_test_and_set
    import voct_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  logic   operation,
    input  coord_t coord_x,
    input  coord_t coord_y,
    input  coord_t coord_z,
    output logic   done,
    output logic   was_filled
);

    store_req_t req;
    byte_t      rd_data;
    logic       clearing;
    logic       accept;
    addr_t      in_addr;

    logic       s1_valid_reg;
    logic       s1_op_reg;
    addr_t      s1_addr_reg;
    logic [2:0] s1_sel_reg;
    logic       fwd_hit_reg;
    logic       fwd_hit_next;
    byte_t      fwd_byte_reg;

    byte_t      cur_byte;
    byte_t      mask;
    byte_t      merged;

    voct_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    assign busy    = clearing;
    assign accept  = start & ~busy;
    assign in_addr = voxel_addr(coord_x, coord_y, coord_z);

    // The memory still holds the old byte when the previous item writes it in the same cycle.
    assign fwd_hit_next = s1_valid_reg && (s1_addr_reg == in_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // A query leaves its byte as it was, so only a fill forwards the merged byte.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= operation;
            s1_addr_reg  <= in_addr;
            s1_sel_reg   <= {coord_z[0], coord_y[0], coord_x[0]};
            fwd_hit_reg  <= fwd_hit_next;
            fwd_byte_reg <= (s1_op_reg == OP_FILL) ? merged : cur_byte;
        end
    end

    always_comb
    begin
        cur_byte   = fwd_hit_reg ? fwd_byte_reg : rd_data;
        mask       = byte_t'(1) << s1_sel_reg;
        merged     = cur_byte | mask;
        was_filled = |(cur_byte & mask);
        done       = s1_valid_reg;

        req.re     = accept;
        req.raddr  = in_addr;
        req.we     = s1_valid_reg & (s1_op_reg == OP_FILL);
        req.waddr  = s1_addr_reg;
        req.wdata  = merged;
    end

endmodule

// ----- rtl/core/voct_checker.sv -----
// Port-level checks for the voxel occupancy block, bound to its top level.
module voct_checker
    import voct_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   start,
    input logic   busy,
    input logic   operation,
    input coord_t coord_x,
    input coord_t coord_y,
    input coord_t coord_z,
    input logic   done,
    input logic   was_filled
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted item gave no result in the next cycle");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without an accepted item");

    a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose again after the clearing sweep");

    a_fill_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation) ##1
        (start && !busy && coord_x == $past(coord_x) && coord_y == $past(coord_y)
            && coord_z == $past(coord_z))
        |=> (done && was_filled))
        else $error("voxel filled by the previous item reported empty");

endmodule

bind voxel_octree_occupancy_test_and_set voct_checker u_voct_checker (.*);

// ----- sim/voxel_occupancy_checker.sv -----
// Checker for the voxel occupancy block: predicts each item's result and compares it.
module voxel_occupancy_checker
    import voct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        operation,
    input  coord_t      coord_x,
    input  coord_t      coord_y,
    input  coord_t      coord_z,
    input  logic        done,
    input  logic        was_filled,
    output int unsigned fail_count,
    output int unsigned pending
);

    localparam int   REPORT_LIMIT = 10;

    typedef struct
    {
        logic   op;
        coord_t x;
        coord_t y;
        coord_t z;
        logic   filled;
    } occupancy_expect_t;

    byte_t             occupancy_model [STORE_BYTES];
    occupancy_expect_t expected_occupancy_q [$];
    occupancy_expect_t oldest;
    occupancy_expect_t incoming;

    // Each tree level contributes one octant digit; levels past the coordinate width read zero.
    function automatic int unsigned octree_byte(coord_t x, coord_t y, coord_t z);
        int unsigned idx;
        idx = 0;
        for (int lvl = 1; lvl <= TREE_LEVELS; lvl++)
        begin
            if (lvl < COORD_W)
            begin
                idx |= int'({z[lvl], y[lvl], x[lvl]}) << (3 * (lvl - 1));
            end
        end
        return idx & (STORE_BYTES - 1);
    endfunction

    function automatic logic predict_occupancy(logic op, coord_t x, coord_t y, coord_t z);
        int unsigned idx;
        byte_t       mask;
        logic        old_bit;
        idx     = octree_byte(x, y, z);
        mask    = byte_t'(1) << {z[0], y[0], x[0]};
        old_bit = |(occupancy_model[idx] & mask);
        if (op == OP_FILL)
        begin
            occupancy_model[idx] = occupancy_model[idx] | mask;
        end
        return old_bit;
    endfunction

    task automatic note_failure(string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("[%0t] %s", $time, what);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            foreach (occupancy_model[i])
            begin
                occupancy_model[i] = '0;
            end
            expected_occupancy_q.delete();
            fail_count = 0;
        end
        else
        begin
            // The result leaving now belongs to an earlier item, so retire it first.
            if (done)
            begin
                if (expected_occupancy_q.size() == 0)
                begin
                    note_failure($sformatf("result was_filled=%b with no item outstanding",
                                           was_filled));
                end
                else
                begin
                    oldest = expected_occupancy_q.pop_front();
                    if (was_filled !== oldest.filled)
                    begin
                        note_failure($sformatf(
                            "op=%b x=%0d y=%0d z=%0d: was_filled expected %b, got %b",
                            oldest.op, oldest.x, oldest.y, oldest.z, oldest.filled,
                            was_filled));
                    end
                end
            end
            if (start && !busy)
            begin
                incoming.op     = operation;
                incoming.x      = coord_x;
                incoming.y      = coord_y;
                incoming.z      = coord_z;
                incoming.filled = predict_occupancy(operation, coord_x, coord_y, coord_z);
                expected_occupancy_q.push_back(incoming);
            end
        end
        pending = expected_occupancy_q.size();
    end

endmodule

// ----- sim/voxel_octree_occupancy_test_and_set_tb.sv -----
// Testbench top for the voxel occupancy block: clock, reset, stimulus and verdict.
module voxel_octree_occupancy_test_and_set_tb;
    import voct_pkg::*;

    localparam int   RANDOM_ITEMS = 550;
    localparam int   CYCLE_LIMIT  = 400000;

    typedef struct
    {
        coord_t x;
        coord_t y;
        coord_t z;
    } voxel_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        operation;
    coord_t      coord_x;
    coord_t      coord_y;
    coord_t      coord_z;
    logic        done;
    logic        was_filled;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;
    voxel_t      touched_voxels [$];

    voxel_octree_occupancy_test_and_set u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .done       (done),
        .was_filled (was_filled)
    );

    voxel_occupancy_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .done       (done),
        .was_filled (was_filled),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("voxel_octree_occupancy_test_and_set_tb: errors");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken,
    // with start still high so that the next item can follow without a gap.
    task automatic drive_voxel(logic op, coord_t x, coord_t y, coord_t z);
        start     <= 1'b1;
        operation <= op;
        coord_x   <= x;
        coord_y   <= y;
        coord_z   <= z;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
    endtask

    task automatic hold_off(int unsigned cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Mostly revisits voxels already touched, or their byte neighbours, so that
    // queries and repeated fills find set bits; the rest lands near the origin or spreads over the grid.
    task automatic pick_voxel(output voxel_t v);
        int unsigned mode;
        mode = $urandom_range(0, 99);
        if (mode < 35 && touched_voxels.size() > 0)
        begin
            v = touched_voxels[$urandom_range(0, touched_voxels.size() - 1)];
        end
        else if (mode < 55 && touched_voxels.size() > 0)
        begin
            v = touched_voxels[$urandom_range(0, touched_voxels.size() - 1)];
            v.x[0] = 1'($urandom_range(0, 1));
            v.y[0] = 1'($urandom_range(0, 1));
            v.z[0] = 1'($urandom_range(0, 1));
        end
        else if (mode < 70)
        begin
            v.x = coord_t'($urandom_range(0, 3));
            v.y = coord_t'($urandom_range(0, 3));
            v.z = coord_t'($urandom_range(0, 3));
        end
        else
        begin
            v.x = coord_t'($urandom);
            v.y = coord_t'($urandom);
            v.z = coord_t'($urandom);
        end
        touched_voxels.push_back(v);
        if (touched_voxels.size() > 48)
        begin
            void'(touched_voxels.pop_front());
        end
    endtask

    task automatic random_phase(int unsigned count, bit with_gaps);
        voxel_t v;
        for (int unsigned i = 0; i < count; i++)
        begin
            pick_voxel(v);
            drive_voxel($urandom_range(0, 1) ? OP_FILL : OP_QUERY, v.x, v.y, v.z);
            if (with_gaps)
            begin
                hold_off(random_gap());
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = OP_QUERY;
        coord_x   = '0;
        coord_y   = '0;
        coord_z   = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Corners, repeated fills and back-to-back accesses to one byte.
        drive_voxel(OP_QUERY, 6'd0,  6'd0,  6'd0);
        drive_voxel(OP_FILL,  6'd0,  6'd0,  6'd0);
        drive_voxel(OP_FILL,  6'd0,  6'd0,  6'd0);
        drive_voxel(OP_QUERY, 6'd0,  6'd0,  6'd0);
        drive_voxel(OP_FILL,  6'd1,  6'd0,  6'd0);
        drive_voxel(OP_QUERY, 6'd1,  6'd0,  6'd0);
        drive_voxel(OP_FILL,  6'd63, 6'd63, 6'd63);
        drive_voxel(OP_QUERY, 6'd63, 6'd63, 6'd63);
        drive_voxel(OP_QUERY, 6'd62, 6'd63, 6'd63);
        drive_voxel(OP_FILL,  6'd0,  6'd63, 6'd0);
        drive_voxel(OP_FILL,  6'd0,  6'd63, 6'd1);
        drive_voxel(OP_QUERY, 6'd0,  6'd63, 6'd1);
        drive_voxel(OP_FILL,  6'd63, 6'd0,  6'd0);
        drive_voxel(OP_QUERY, 6'd62, 6'd0,  6'd0);
        drive_voxel(OP_QUERY, 6'd63, 6'd0,  6'd0);
        drive_voxel(OP_FILL,  6'd0,  6'd0,  6'd63);
        hold_off(3);
        drive_voxel(OP_QUERY, 6'd0,  6'd0,  6'd63);
        drive_voxel(OP_FILL,  6'd42, 6'd21, 6'd42);
        drive_voxel(OP_QUERY, 6'd42, 6'd21, 6'd42);
        drive_voxel(OP_QUERY, 6'd21, 6'd42, 6'd21);
        hold_off(5);

        random_phase(200, 1'b1);
        // Let the block drain completely before carrying on.
        hold_off(1);
        while (pending != 0) @(negedge clk);
        random_phase(150, 1'b0);
        hold_off(random_gap() + 1);
        random_phase(RANDOM_ITEMS - 350, 1'b1);
        hold_off(1);

        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("voxel_octree_occupancy_test_and_set_tb: clean");
        end
        else
        begin
            $display("voxel_octree_occupancy_test_and_set_tb: errors");
        end
        $finish;
    end

endmodule
